FILE: design/pfdc_pkg.sv
// Package for the PID flow duty controller: widths, register indexes, shared types.
`timescale 1ns / 1ps
`default_nettype none

package pfdc_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 32;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int TARGET_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int DUTY_W    = 16;
   localparam int FRAC_W    = 20;

   // error = target - sample, one bit wider than the wider operand
   localparam int ERR_W   = ((SAMPLE_WIDTH > TARGET_W) ? SAMPLE_WIDTH : TARGET_W) + 1;
   localparam int DERIV_W = ERR_W + 1;
   localparam int SUM_W   = ((ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W) + 1;

   localparam int OPND_MAX_A = (ACC_WIDTH > DERIV_W) ? ACC_WIDTH : DERIV_W;
   localparam int OPND_MAX   = (OPND_MAX_A > FRAC_W + 1) ? OPND_MAX_A : FRAC_W + 1;
   // three products of a 16-bit unsigned gain plus two bits of carry room
   localparam int CTRL_W = OPND_MAX + GAIN_W + 2;
   localparam int CNT_W  = $clog2(GAIN_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOW_TARGET     = 3'd0,
      CSR_GAIN_PROP       = 3'd1,
      CSR_GAIN_INTEG      = 3'd2,
      CSR_GAIN_DERIV      = 3'd3,
      CSR_DUTY_FULL_SCALE = 3'd4
   } csr_index_type;

   localparam logic [CSR_W-1:0] RST_FLOW_TARGET     = 16'd0;
   localparam logic [CSR_W-1:0] RST_GAIN_PROP       = 16'd4096;
   localparam logic [CSR_W-1:0] RST_GAIN_INTEG      = 16'd0;
   localparam logic [CSR_W-1:0] RST_GAIN_DERIV      = 16'd0;
   localparam logic [CSR_W-1:0] RST_DUTY_FULL_SCALE = 16'd1023;

   typedef struct packed {
      logic start;
      logic clear;
   } mac_cmd_type;

endpackage

`default_nettype wire

FILE: design/pfdc_error_unit.sv
// Error, saturating integral and derivative for one request; holds the loop state.
`timescale 1ns / 1ps
`default_nettype none

module pfdc_error_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    load,
   input  wire logic [pfdc_pkg::SAMPLE_WIDTH-1:0]       sample,
   input  wire logic [pfdc_pkg::TARGET_W-1:0]           target,
   output logic signed [pfdc_pkg::ERR_W-1:0]            err,
   output logic signed [pfdc_pkg::ACC_WIDTH-1:0]        integ,
   output logic signed [pfdc_pkg::DERIV_W-1:0]          deriv
);
   import pfdc_pkg::*;

   logic signed [ERR_W-1:0]     last_error_ff, last_error_in;
   logic signed [ACC_WIDTH-1:0] error_sum_ff, error_sum_in;
   logic signed [DERIV_W-1:0]   deriv_ff, deriv_in;
   logic signed [SUM_W-1:0]     sum_raw;
   logic                        sum_ovf;

   always_comb begin
      last_error_in = $signed(ERR_W'(target)) - $signed(ERR_W'(sample));
      deriv_in      = DERIV_W'(last_error_in) - DERIV_W'(last_error_ff);
      sum_raw       = SUM_W'(error_sum_ff) + SUM_W'(last_error_in);
      // in range when every bit from the accumulator sign upward agrees
      sum_ovf = !((&sum_raw[SUM_W-1:ACC_WIDTH-1]) || !(|sum_raw[SUM_W-1:ACC_WIDTH-1]));
      if (sum_ovf) begin
         error_sum_in = sum_raw[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                         : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         error_sum_in = sum_raw[ACC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (load) begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         deriv_ff <= deriv_in;
      end
   end

   assign err   = last_error_ff;
   assign integ = error_sum_ff;
   assign deriv = deriv_ff;

endmodule

`default_nettype wire

FILE: design/pfdc_serial_mac.sv
// Bit-serial multiply-accumulate: one multiplier bit per cycle, shared by all passes.
`timescale 1ns / 1ps
`default_nettype none

module pfdc_serial_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pfdc_pkg::mac_cmd_type                cmd,
   input  wire logic signed [pfdc_pkg::CTRL_W-1:0]   operand,
   input  wire logic [pfdc_pkg::GAIN_W-1:0]          multiplier,
   output logic                                      done,
   output logic signed [pfdc_pkg::CTRL_W-1:0]        acc
);
   import pfdc_pkg::*;

   logic signed [CTRL_W-1:0] mcand_ff, mcand_in;
   logic [GAIN_W-1:0]        mult_ff, mult_in;
   logic signed [CTRL_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;

   always_comb begin
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (cmd.start) begin
         mcand_in = operand;
         mult_in  = multiplier;
         cnt_in   = CNT_W'(GAIN_W - 1);
         busy_in  = 1'b1;
         if (cmd.clear) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (mult_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mult_in  = mult_ff >> 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
      acc_ff   <= acc_in;
   end

   // last partial product lands at this edge
   assign done = busy_ff && (cnt_ff == '0);
   assign acc  = acc_ff;

endmodule

`default_nettype wire

FILE: design/pid_flow_duty_controller.sv
// PID flow controller top level: registers, pass sequencer, clamp and result register.
//
// Usage:
//   Request channel (req_valid / req_stall / req_flow_sample): one unsigned Q8.8
//   flow sample per control tick. req_stall is high while a request is in work.
//   Response channel (rsp_valid / rsp_stall / rsp_*): one duty count per request,
//   with flags for clamping at 1.0 (hit_upper) or at 0 (hit_lower).
//   CSR port (csr_write / csr_index / csr_wdata): write target, three Q4.12 gains
//   and the duty full scale; write only while no request is in flight.
// Sequencing:
//   A request runs as four passes of the bit-serial multiplier (P, I, D terms,
//   then full-scale scaling), each a start step followed by one step per
//   gain/scale bit, with a clamp step before the scaling pass and the response
//   register at the end. A new request is taken only once the sequencer is idle
//   again, so requests do not overlap; the serial multiplier sets the pace.
// Reset:
//   Synchronous, active high. Integral and previous error go to zero, registers to
//   their defaults, and both channels go idle.
// Back-pressure:
//   The response register holds while rsp_stall is high. A finished result waits
//   in the sequencer until the response register frees, and req_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module pid_flow_duty_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pfdc_pkg::SAMPLE_WIDTH-1:0]   req_flow_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pfdc_pkg::DUTY_W-1:0]              rsp_duty_count,
   output logic                                     rsp_hit_upper,
   output logic                                     rsp_hit_lower,
   input  wire logic                                csr_write,
   input  wire logic [pfdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pfdc_pkg::CSR_W-1:0]          csr_wdata
);
   import pfdc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_WAIT  = 5'b00100,
      S_CLAMP = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      PASS_PROP  = 2'd0,
      PASS_INTEG = 2'd1,
      PASS_DERIV = 2'd2,
      PASS_SCALE = 2'd3
   } pass_type;

   localparam logic signed [CTRL_W-1:0] CTRL_ONE = CTRL_W'(1) <<< FRAC_W;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   logic [CSR_W-1:0] target_ff, gain_p_ff, gain_i_ff, gain_d_ff, full_scale_ff;

   logic                     req_accept;
   logic signed [ERR_W-1:0]     err;
   logic signed [ACC_WIDTH-1:0] integ;
   logic signed [DERIV_W-1:0]   deriv;

   mac_cmd_type              mac_cmd;
   logic signed [CTRL_W-1:0] mac_operand;
   logic [GAIN_W-1:0]        mac_mult;
   logic                     mac_done;
   logic signed [CTRL_W-1:0] mac_acc;

   logic [FRAC_W:0] clamped_ff, clamped_in;
   logic            up_ff, up_in, lo_ff, lo_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] duty_ff;
   logic              hit_upper_ff, hit_lower_ff;
   logic              rsp_load;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= RST_FLOW_TARGET;
         gain_p_ff     <= RST_GAIN_PROP;
         gain_i_ff     <= RST_GAIN_INTEG;
         gain_d_ff     <= RST_GAIN_DERIV;
         full_scale_ff <= RST_DUTY_FULL_SCALE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FLOW_TARGET:     target_ff     <= csr_wdata;
            CSR_GAIN_PROP:       gain_p_ff     <= csr_wdata;
            CSR_GAIN_INTEG:      gain_i_ff     <= csr_wdata;
            CSR_GAIN_DERIV:      gain_d_ff     <= csr_wdata;
            CSR_DUTY_FULL_SCALE: full_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   pfdc_error_unit u_error (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .sample (req_flow_sample),
      .target (target_ff[TARGET_W-1:0]),
      .err    (err),
      .integ  (integ),
      .deriv  (deriv)
   );

   always_comb begin
      unique case (pass_ff)
         PASS_PROP: begin
            mac_operand = CTRL_W'(err);
            mac_mult    = gain_p_ff;
         end
         PASS_INTEG: begin
            mac_operand = CTRL_W'(integ);
            mac_mult    = gain_i_ff;
         end
         PASS_DERIV: begin
            mac_operand = CTRL_W'(deriv);
            mac_mult    = gain_d_ff;
         end
         PASS_SCALE: begin
            mac_operand = $signed(CTRL_W'(clamped_ff));
            mac_mult    = full_scale_ff;
         end
         default: begin
            mac_operand = '0;
            mac_mult    = '0;
         end
      endcase
   end

   assign mac_cmd.start = (state_ff == S_START);
   assign mac_cmd.clear = (pass_ff == PASS_PROP) || (pass_ff == PASS_SCALE);

   pfdc_serial_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mac_cmd),
      .operand    (mac_operand),
      .multiplier (mac_mult),
      .done       (mac_done),
      .acc        (mac_acc)
   );

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      clamped_in = clamped_ff;
      up_in      = up_ff;
      lo_in      = lo_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_START;
               pass_in  = PASS_PROP;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mac_done) begin
               priority if (pass_ff == PASS_DERIV) begin
                  state_in = S_CLAMP;
               end else if (pass_ff == PASS_SCALE) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_START;
                  pass_in  = pass_type'(pass_ff + 2'd1);
               end
            end
         end
         S_CLAMP: begin
            // exactly 0 or exactly 1.0 passes unflagged
            priority if (mac_acc < 0) begin
               clamped_in = '0;
               lo_in      = 1'b1;
               up_in      = 1'b0;
            end else if (mac_acc > CTRL_ONE) begin
               clamped_in = CTRL_ONE[FRAC_W:0];
               lo_in      = 1'b0;
               up_in      = 1'b1;
            end else begin
               clamped_in = mac_acc[FRAC_W:0];
               lo_in      = 1'b0;
               up_in      = 1'b0;
            end
            pass_in  = PASS_SCALE;
            state_in = S_START;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= PASS_PROP;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      clamped_ff <= clamped_in;
      up_ff      <= up_in;
      lo_ff      <= lo_in;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         duty_ff      <= mac_acc[FRAC_W +: DUTY_W];
         hit_upper_ff <= up_ff;
         hit_lower_ff <= lo_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_count = duty_ff;
   assign rsp_hit_upper  = hit_upper_ff;
   assign rsp_hit_lower  = hit_lower_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit_upper && rsp_hit_lower))
      else $error("both clamp flags set");

   a_upper_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_upper) |-> (rsp_duty_count == full_scale_ff))
      else $error("upper clamp without full-scale duty");

   a_lower_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_lower) |-> (rsp_duty_count == '0))
      else $error("lower clamp with nonzero duty");

   a_mac_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == S_WAIT))
      else $error("multiplier finished outside wait state");

endmodule

`default_nettype wire

FILE: tb/sv/tb_pid_flow_duty_controller.sv
// Testbench for the PID flow duty controller: request driver, response scoreboard, run control.
`timescale 1ns / 1ps

module tb_pid_flow_duty_controller;
   import pfdc_pkg::*;

   localparam longint ACC_MAX  = (longint'(1) << (ACC_WIDTH - 1)) - 1;
   localparam longint ACC_MIN  = -(longint'(1) << (ACC_WIDTH - 1));
   localparam longint CTRL_ONE = longint'(1) << FRAC_W;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LAST = '1;
   localparam int SAMPLE_MAX = (1 << SAMPLE_WIDTH) - 1;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_REQUESTS = 50;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_count;
      logic              hit_upper;
      logic              hit_lower;
   } duty_result_type;

   class duty_scoreboard_type;
      logic [CSR_W-1:0] flow_target, gain_prop, gain_integ, gain_deriv, duty_full_scale;
      longint error_sum, last_error;
      duty_result_type pending_duty[$];
      int errors, requests, responses, upper_seen, lower_seen;

      function new();
         flow_target     = RST_FLOW_TARGET;
         gain_prop       = RST_GAIN_PROP;
         gain_integ      = RST_GAIN_INTEG;
         gain_deriv      = RST_GAIN_DERIV;
         duty_full_scale = RST_DUTY_FULL_SCALE;
         error_sum       = 0;
         last_error      = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
         case (idx)
            CSR_FLOW_TARGET:     flow_target = value;
            CSR_GAIN_PROP:       gain_prop = value;
            CSR_GAIN_INTEG:      gain_integ = value;
            CSR_GAIN_DERIV:      gain_deriv = value;
            CSR_DUTY_FULL_SCALE: duty_full_scale = value;
            default: ;
         endcase
      endfunction

      // Works out the duty for one accepted request and advances the PID state.
      function void note_request(input logic [SAMPLE_WIDTH-1:0] sample);
         longint err, deriv, acc, ctrl;
         duty_result_type r;
         err   = longint'(flow_target) - longint'(sample);
         deriv = err - last_error;
         acc   = error_sum + err;
         if (acc > ACC_MAX) acc = ACC_MAX;
         if (acc < ACC_MIN) acc = ACC_MIN;
         error_sum = acc;
         // 16-bit gains against these operands stay far inside 64 bits
         ctrl = longint'(gain_prop) * err + longint'(gain_integ) * acc
              + longint'(gain_deriv) * deriv;
         r.hit_upper = 1'b0;
         r.hit_lower = 1'b0;
         if (ctrl < 0) begin
            ctrl = 0;
            r.hit_lower = 1'b1;
         end else if (ctrl > CTRL_ONE) begin
            ctrl = CTRL_ONE;
            r.hit_upper = 1'b1;
         end
         r.duty_count = DUTY_W'((ctrl * longint'(duty_full_scale)) >>> FRAC_W);
         last_error = err;
         pending_duty.push_back(r);
         requests++;
      endfunction

      function void check_response(input logic [DUTY_W-1:0] duty, input logic up,
                                   input logic lo);
         duty_result_type want;
         responses++;
         if (pending_duty.size() == 0) begin
            $display("%0t: response duty=%0d upper=%0b lower=%0b with no request pending",
                     $time, duty, up, lo);
            errors++;
            return;
         end
         want = pending_duty.pop_front();
         if (duty !== want.duty_count) begin
            $display("%0t: duty_count expected %0d actual %0d", $time, want.duty_count, duty);
            errors++;
         end
         if (up !== want.hit_upper) begin
            $display("%0t: hit_upper expected %0b actual %0b", $time, want.hit_upper, up);
            errors++;
         end
         if (lo !== want.hit_lower) begin
            $display("%0t: hit_lower expected %0b actual %0b", $time, want.hit_lower, lo);
            errors++;
         end
         if (want.hit_upper) upper_seen++;
         if (want.hit_lower) lower_seen++;
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SAMPLE_WIDTH-1:0] req_flow_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DUTY_W-1:0]       rsp_duty_count;
   logic                    rsp_hit_upper;
   logic                    rsp_hit_lower;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   duty_scoreboard_type sb = new();
   bit driving = 1'b0;
   int burst_left = 0;

   pid_flow_duty_controller dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_flow_sample (req_flow_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_duty_count  (rsp_duty_count),
      .rsp_hit_upper   (rsp_hit_upper),
      .rsp_hit_lower   (rsp_hit_lower),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("pid_flow_duty_controller verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_duty_count, rsp_hit_upper, rsp_hit_lower);
   end

   // Receiver back-pressure: switches between free-running, sparse, long-run and heavy stalls.
   int stall_mode = 0;
   int mode_left = 0;
   int run_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(100, 800);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: begin
               if (run_left == 0) begin
                  rsp_stall <= !rsp_stall;
                  run_left  <= $urandom_range(1, 40);
               end else begin
                  run_left <= run_left - 1;
               end
            end
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic load_settings(input logic [CSR_W-1:0] target, gp, gi, gd, fs,
                                input bit poke_unused);
      put_reg(CSR_FLOW_TARGET, target);
      put_reg(CSR_GAIN_PROP, gp);
      put_reg(CSR_GAIN_INTEG, gi);
      put_reg(CSR_GAIN_DERIV, gd);
      put_reg(CSR_DUTY_FULL_SCALE, fs);
      // writes past the last register must leave every setting alone
      if (poke_unused)
         for (int i = CSR_DUTY_FULL_SCALE + 1; i <= CSR_IDX_LAST; i++)
            put_reg(CSR_IDX_W'(i), CSR_W'($urandom));
      csr_write <= 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] sample, input bit allow_gap);
      req_valid       <= 1'b1;
      req_flow_sample <= sample;
      driving = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(sample);
      if (allow_gap) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            driving = 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Hold off until every request has produced its response.
   task automatic drain;
      if (driving) begin
         req_valid <= 1'b0;
         driving = 1'b0;
      end
      while (sb.pending_duty.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CSR_W-1:0] pick_gain(input int top);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CSR_W'($urandom_range(0, top));
      endcase
   endfunction

   // Mostly samples that keep the loop near its target, steered against the integral.
   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      int mode, err_want, s;
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
         err_want = int'($urandom_range(0, 768)) - 384 - int'(sb.error_sum / 8);
         if (err_want > 4096) err_want = 4096;
         if (err_want < -4096) err_want = -4096;
         s = int'(sb.flow_target) - err_want;
         if (s < 0) s = 0;
         if (s > SAMPLE_MAX) s = SAMPLE_MAX;
         return SAMPLE_WIDTH'(s);
      end else if (mode <= 8) begin
         return SAMPLE_WIDTH'($urandom_range(0, SAMPLE_MAX));
      end
      return ($urandom_range(0, 1) == 1) ? '1 : '0;
   endfunction

   initial begin
      logic [CSR_W-1:0] target, fs;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings: zero error gives exactly zero, negative error clamps low
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(SAMPLE_WIDTH'(1), 1'b0);
      drain();

      // unity gain, target 1.0: zero sample lands exactly on 1.0
      load_settings(16'd256, 16'd4096, 16'd0, 16'd0, 16'hFFFF, 1'b1);
      send_sample('0, 1'b0);
      send_sample(SAMPLE_WIDTH'(1), 1'b0);
      send_sample(SAMPLE_WIDTH'(257), 1'b0);
      send_sample(SAMPLE_WIDTH'(128), 1'b0);
      drain();

      // all gains at full scale, smallest nonzero full scale
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(SAMPLE_WIDTH'(16'hAAAA), 1'b0);
      send_sample(SAMPLE_WIDTH'(16'h5555), 1'b0);
      drain();

      // zero full scale must give zero duty
      load_settings(16'h8000, 16'd0, 16'd0, 16'd4096, 16'd0, 1'b0);
      send_sample(SAMPLE_WIDTH'(16'h7F00), 1'b0);
      send_sample(SAMPLE_WIDTH'(16'h8100), 1'b0);
      drain();

      // derivative only
      load_settings(16'd1000, 16'd0, 16'd0, 16'd4096, 16'd1000, 1'b0);
      send_sample(SAMPLE_WIDTH'(1000), 1'b0);
      send_sample(SAMPLE_WIDTH'(744), 1'b0);
      send_sample(SAMPLE_WIDTH'(1000), 1'b0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 3))
            0: target = '0;
            1: target = '1;
            default: target = CSR_W'($urandom_range(0, SAMPLE_MAX));
         endcase
         case ($urandom_range(0, 15))
            0, 1: fs = 16'd1;
            2, 3: fs = '1;
            4: fs = '0;
            default: fs = CSR_W'($urandom_range(1, 65535));
         endcase
         load_settings(target, pick_gain(8192), pick_gain(64), pick_gain(8192), fs,
                       ($urandom_range(0, 3) == 0));
         for (int i = 0; i < PHASE_REQUESTS; i++)
            send_sample(pick_sample(), 1'b1);
         drain();
      end

      repeat (100) @(posedge clock);
      $display("%0d requests, %0d responses: %0d clamped high, %0d clamped low",
               sb.requests, sb.responses, sb.upper_seen, sb.lower_seen);
      $display("directed clamp and zero-scale cases, then %0d random setting phases",
               RANDOM_PHASES);
      if (sb.errors == 0 && sb.pending_duty.size() == 0)
         $display("pid_flow_duty_controller verification clean");
      else
         $display("pid_flow_duty_controller verification failed");
      $finish;
   end

endmodule

FILE: sim.f
design/pfdc_pkg.sv
design/pfdc_error_unit.sv
design/pfdc_serial_mac.sv
design/pid_flow_duty_controller.sv
tb/sv/tb_pid_flow_duty_controller.sv
